FILE: sv/lav_pkg.sv
package lav_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // scaling window: largest magnitude lands in [2^SC_LO, 2^(SC_LO+1))
  localparam int SC_LO    = 28;
  localparam int SC_BITS  = SC_LO + 1;
  localparam int SCL_BITS = 72;
  localparam int POS_BITS = 7;

  localparam logic [1:0] ROW_SIDE = 2'd0;
  localparam logic [1:0] ROW_UP   = 2'd1;
  localparam logic [1:0] ROW_FWD  = 2'd2;
  localparam logic [1:0] ROW_LAST = 2'd3;

  function automatic logic [POS_BITS-1:0] msb_pos(input logic [SCL_BITS-1:0] v);
    logic [POS_BITS-1:0] p;
    p = '0;
    for (int i = 0; i < SCL_BITS; i++) begin
      if (v[i]) p = POS_BITS'(i);
    end
    return p;
  endfunction

  // right shifts truncate the magnitude, i.e. toward zero on the signed value
  function automatic logic [SC_BITS-1:0] scale_mag(input logic [SCL_BITS-1:0] v,
                                                  input logic [POS_BITS-1:0] p);
    logic [SCL_BITS-1:0] t;
    if (p >= POS_BITS'(SC_LO)) begin
      t = v >> (p - POS_BITS'(SC_LO));
    end else begin
      t = v << (POS_BITS'(SC_LO) - p);
    end
    return t[SC_BITS-1:0];
  endfunction

endpackage

FILE: sv/lav_if.sv
interface lav_req_if #(
  parameter int WORD_BITS = lav_pkg::WORD_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] eye_x;
  logic signed [WORD_BITS-1:0] eye_y;
  logic signed [WORD_BITS-1:0] eye_z;
  logic signed [WORD_BITS-1:0] target_x;
  logic signed [WORD_BITS-1:0] target_y;
  logic signed [WORD_BITS-1:0] target_z;
  logic signed [WORD_BITS-1:0] upward_x;
  logic signed [WORD_BITS-1:0] upward_y;
  logic signed [WORD_BITS-1:0] upward_z;

  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  upward_x, upward_y, upward_z, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                upward_x, upward_y, upward_z, output ready);
endinterface

interface lav_rsp_if #(
  parameter int WORD_BITS = lav_pkg::WORD_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  row_index;
  logic signed [WORD_BITS-1:0] col0;
  logic signed [WORD_BITS-1:0] col1;
  logic signed [WORD_BITS-1:0] col2;
  logic signed [WORD_BITS-1:0] col3;
  logic                        last_row;
  logic                        degenerate;

  modport source (output valid, row_index, col0, col1, col2, col3, last_row, degenerate,
                  input ready);
  modport sink (input valid, row_index, col0, col1, col2, col3, last_row, degenerate,
                output ready);
endinterface

FILE: sv/lav_norm.sv
module lav_norm #(
  parameter int MW        = 33,
  parameter int FRAC_BITS = 16,
  parameter int SIDE_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [2:0]                in_sgn,
  input  logic [2:0][MW-1:0]        in_mag,
  input  logic [SIDE_BITS-1:0]      in_side,
  output logic                      out_valid,
  output logic                      out_ok,
  output logic [2:0][FRAC_BITS+1:0] out_vec,
  output logic [SIDE_BITS-1:0]      out_side
);

  localparam int QB    = FRAC_BITS + 1;
  localparam int FS    = QB + 1;
  localparam int SCB   = lav_pkg::SC_BITS;
  localparam int NB    = 2 * SCB + 2;
  localparam int RB    = NB + 1;
  localparam int LB    = SCB + 1;
  localparam int STEPS = SCB + 1;
  localparam int DNB   = SCB + FRAC_BITS + 1;

  typedef struct packed {
    logic [SIDE_BITS-1:0]     side;
    logic [2:0]               sgn;
    logic                     zero;
    logic [2:0][SCB-1:0]      sc;
    logic [NB-1:0]            n;
    logic [RB-1:0]            r;
  } root_t;

  typedef struct packed {
    logic [SIDE_BITS-1:0]     side;
    logic [2:0]               sgn;
    logic                     zero;
    logic [LB-1:0]            len;
    logic [2:0][DNB-1:0]      rem;
    logic [2:0][QB-1:0]       q;
  } quo_t;

  function automatic root_t root_step(input root_t x, input int k);
    root_t         y;
    logic [RB-1:0] bitv;
    logic [RB-1:0] t;
    y    = x;
    bitv = RB'(1) << (2 * (STEPS - 1 - k));
    t    = x.r + bitv;
    if ({1'b0, x.n} >= t) begin
      y.n = x.n - t[NB-1:0];
      y.r = (x.r >> 1) + bitv;
    end else begin
      y.r = x.r >> 1;
    end
    return y;
  endfunction

  function automatic quo_t quo_step(input quo_t x, input int j);
    quo_t           y;
    logic [DNB-1:0] dv;
    y  = x;
    dv = DNB'(x.len) << (QB - 1 - j);
    for (int i = 0; i < 3; i++) begin
      if (x.rem[i] >= dv) begin
        y.rem[i]             = x.rem[i] - dv;
        y.q[i][QB - 1 - j]   = 1'b1;
      end
    end
    return y;
  endfunction

  logic                     a_v, b_v, c_v, d_v;
  logic [2:0]               a_sgn, b_sgn, c_sgn, d_sgn;
  logic [2:0][MW-1:0]       a_mag, b_mag;
  logic [SIDE_BITS-1:0]     a_side, b_side, c_side, d_side;
  logic [lav_pkg::POS_BITS-1:0] b_p;
  logic                     b_zero, c_zero, d_zero;
  logic [2:0][SCB-1:0]      c_sc, d_sc;
  logic [2:0][2*SCB-1:0]    d_sq;
  logic [MW-1:0]            mx;

  root_t                    rt_q [STEPS+1];
  logic [STEPS:0]           rt_v;
  quo_t                     qt_q [QB+1];
  logic [QB:0]              qt_v;

  always_comb begin
    mx = a_mag[0];
    if (a_mag[1] > mx) mx = a_mag[1];
    if (a_mag[2] > mx) mx = a_mag[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v  <= 1'b0;
      b_v  <= 1'b0;
      c_v  <= 1'b0;
      d_v  <= 1'b0;
      rt_v <= '0;
      qt_v <= '0;
    end else if (en) begin
      a_v  <= in_valid;
      b_v  <= a_v;
      c_v  <= b_v;
      d_v  <= c_v;
      rt_v <= {rt_v[STEPS-1:0], d_v};
      qt_v <= {qt_v[QB-1:0], rt_v[STEPS]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sgn  <= in_sgn;
      a_mag  <= in_mag;
      a_side <= in_side;

      b_sgn  <= a_sgn;
      b_mag  <= a_mag;
      b_side <= a_side;
      b_p    <= lav_pkg::msb_pos(lav_pkg::SCL_BITS'(mx));
      b_zero <= (mx == '0);

      c_sgn  <= b_sgn;
      c_side <= b_side;
      c_zero <= b_zero;
      for (int i = 0; i < 3; i++) begin
        c_sc[i] <= lav_pkg::scale_mag(lav_pkg::SCL_BITS'(b_mag[i]), b_p);
      end

      d_sgn  <= c_sgn;
      d_side <= c_side;
      d_zero <= c_zero;
      d_sc   <= c_sc;
      for (int i = 0; i < 3; i++) begin
        d_sq[i] <= c_sc[i] * c_sc[i];
      end

      rt_q[0].side <= d_side;
      rt_q[0].sgn  <= d_sgn;
      rt_q[0].zero <= d_zero;
      rt_q[0].sc   <= d_sc;
      rt_q[0].n    <= NB'(d_sq[0]) + NB'(d_sq[1]) + NB'(d_sq[2]);
      rt_q[0].r    <= '0;
      for (int k = 0; k < STEPS; k++) begin
        rt_q[k+1] <= root_step(rt_q[k], k);
      end

      // numerator is (|v| << FRAC) + len/2 for round to nearest
      qt_q[0].side <= rt_q[STEPS].side;
      qt_q[0].sgn  <= rt_q[STEPS].sgn;
      qt_q[0].zero <= rt_q[STEPS].zero;
      qt_q[0].len  <= rt_q[STEPS].r[LB-1:0];
      qt_q[0].q    <= '0;
      for (int i = 0; i < 3; i++) begin
        qt_q[0].rem[i] <= (DNB'(rt_q[STEPS].sc[i]) << FRAC_BITS)
                          + DNB'(rt_q[STEPS].r[LB-1:1]);
      end
      for (int j = 0; j < QB; j++) begin
        qt_q[j+1] <= quo_step(qt_q[j], j);
      end
    end
  end

  always_comb begin
    out_valid = qt_v[QB];
    out_ok    = !qt_q[QB].zero;
    out_side  = qt_q[QB].side;
    for (int i = 0; i < 3; i++) begin
      if (qt_q[QB].zero) begin
        out_vec[i] = '0;
      end else if (qt_q[QB].sgn[i]) begin
        out_vec[i] = FS'(0) - FS'(qt_q[QB].q[i]);
      end else begin
        out_vec[i] = FS'(qt_q[QB].q[i]);
      end
    end
  end

endmodule

FILE: sv/look_at_view_matrix_top.sv
// Channel  Dir  Beat
// req      in   eye, target and up vectors, nine signed fixed-point words
// rsp      out  one matrix row: row_index, col0..col3, last_row, degenerate
//
// Each request gives four rsp beats, one per cycle while rsp.ready is high, so while the
// serializer holds rows a request is taken only with the last beat; while the serializer
// is empty a request enters every cycle. The row serializer sets that.
// The first rsp beat follows the request through two normalize pipelines of 4 scaling
// stages, a 30-step square root and a (FRAC_BITS+1)-step divider each, with the input,
// difference, cross, dot-product and serializer stages around them; stalls hold it back.
// Reset (rst, synchronous) empties the pipeline; there is no other state.
// One enable moves all stages; it drops only while the serializer still holds rows.
module look_at_view_matrix_top #(
  parameter int WORD_BITS = lav_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input logic     clk,
  input logic     rst,
  lav_req_if.sink req,
  lav_rsp_if.source rsp
);

  localparam int W   = WORD_BITS;
  localparam int DW  = W + 1;
  localparam int FS  = FRAC_BITS + 2;
  localparam int SCB = lav_pkg::SC_BITS;
  localparam int PW  = FS + SCB + 1;
  localparam int AW  = 2 * W + FRAC_BITS + 8;

  localparam logic signed [AW-1:0] HALF    = AW'(1) << (FRAC_BITS - 1);
  localparam logic signed [AW-1:0] HALF_M1 = HALF - AW'(1);
  localparam logic signed [AW-1:0] MAXV    = (AW'(1) << (W - 1)) - AW'(1);
  localparam logic signed [AW-1:0] MINV    = AW'(0) - (AW'(1) << (W - 1));

  function automatic logic signed [W-1:0] clamp(input logic signed [AW-1:0] x);
    logic signed [W-1:0] y;
    if (x > MAXV) begin
      y = MAXV[W-1:0];
    end else if (x < MINV) begin
      y = MINV[W-1:0];
    end else begin
      y = x[W-1:0];
    end
    return y;
  endfunction

  // round to FRAC_BITS, ties away from zero, then saturate
  function automatic logic signed [W-1:0] rnd(input logic signed [AW-1:0] x);
    logic signed [AW-1:0] y;
    y = x + ((x < 0) ? HALF_M1 : HALF);
    y = y >>> FRAC_BITS;
    return clamp(y);
  endfunction

  function automatic logic signed [DW-1:0] half_tz(input logic signed [W-1:0] x);
    logic signed [DW-1:0] t;
    t = DW'(x);
    if (x < 0) t = t + DW'(1);
    return t >>> 1;
  endfunction

  localparam logic signed [W-1:0] ONE_W = clamp(AW'(1) << FRAC_BITS);

  typedef struct packed {
    logic [2:0][W-1:0]   eye;
    logic [2:0]          up_sgn;
    logic [2:0][SCB-1:0] up_sc;
  } n1_side_t;

  typedef struct packed {
    logic [2:0][W-1:0]  eye;
    logic [2:0][FS-1:0] f;
    logic               fok;
  } n2_side_t;

  logic adv;

  // input and difference stages
  logic                       t0_v, t1_v;
  logic signed [W-1:0]        t0_eye [3];
  logic signed [W-1:0]        t0_tgt [3];
  logic signed [W-1:0]        t0_up  [3];
  logic [2:0][W-1:0]          t1_eye;
  logic [2:0]                 t1_dsgn, t1_usgn;
  logic [2:0][DW-1:0]         t1_dmag;
  logic [2:0][W-1:0]          t1_umag;
  logic [lav_pkg::POS_BITS-1:0] t1_up;
  logic signed [DW-1:0]       d_c [3];
  logic [W-1:0]               um_c [3];
  logic [W-1:0]               umx;
  n1_side_t                   n1_in_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (W > 62) begin
        d_c[i] = half_tz(t0_tgt[i]) - half_tz(t0_eye[i]);
      end else begin
        d_c[i] = DW'(t0_tgt[i]) - DW'(t0_eye[i]);
      end
      um_c[i] = (t0_up[i] < 0) ? W'(-t0_up[i]) : W'(t0_up[i]);
    end
    umx = um_c[0];
    if (um_c[1] > umx) umx = um_c[1];
    if (um_c[2] > umx) umx = um_c[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t0_v <= 1'b0;
      t1_v <= 1'b0;
    end else if (adv) begin
      t0_v <= req.valid;
      t1_v <= t0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t0_eye[0] <= req.eye_x;
      t0_eye[1] <= req.eye_y;
      t0_eye[2] <= req.eye_z;
      t0_tgt[0] <= req.target_x;
      t0_tgt[1] <= req.target_y;
      t0_tgt[2] <= req.target_z;
      t0_up[0]  <= req.upward_x;
      t0_up[1]  <= req.upward_y;
      t0_up[2]  <= req.upward_z;
      for (int i = 0; i < 3; i++) begin
        t1_eye[i]  <= t0_eye[i];
        t1_dsgn[i] <= d_c[i] < 0;
        t1_dmag[i] <= (d_c[i] < 0) ? DW'(-d_c[i]) : DW'(d_c[i]);
        t1_usgn[i] <= t0_up[i] < 0;
        t1_umag[i] <= um_c[i];
      end
      t1_up <= lav_pkg::msb_pos(lav_pkg::SCL_BITS'(umx));
    end
  end

  always_comb begin
    n1_in_side.eye    = t1_eye;
    n1_in_side.up_sgn = t1_usgn;
    for (int i = 0; i < 3; i++) begin
      n1_in_side.up_sc[i] = lav_pkg::scale_mag(lav_pkg::SCL_BITS'(t1_umag[i]), t1_up);
    end
  end

  // forward vector
  logic               n1_v, n1_ok;
  logic [2:0][FS-1:0] n1_vec;
  n1_side_t           n1_side;

  lav_norm #(
    .MW        (DW),
    .FRAC_BITS (FRAC_BITS),
    .SIDE_BITS ($bits(n1_side_t))
  ) u_norm_fwd (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (t1_v),
    .in_sgn    (t1_dsgn),
    .in_mag    (t1_dmag),
    .in_side   (n1_in_side),
    .out_valid (n1_v),
    .out_ok    (n1_ok),
    .out_vec   (n1_vec),
    .out_side  (n1_side)
  );

  // forward cross up
  logic                  c1_v;
  logic signed [PW-1:0]  c1_pa [3];
  logic signed [PW-1:0]  c1_pb [3];
  n2_side_t              c1_side;
  logic signed [SCB:0]   upv [3];
  logic signed [FS-1:0]  fv [3];
  logic signed [PW:0]    cd [3];
  logic [2:0]            c_sgn;
  logic [2:0][PW-1:0]    c_mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      upv[i] = n1_side.up_sgn[i] ? -$signed({1'b0, n1_side.up_sc[i]})
                                 : $signed({1'b0, n1_side.up_sc[i]});
      fv[i]  = $signed(n1_vec[i]);
      cd[i]  = (PW + 1)'(c1_pa[i]) - (PW + 1)'(c1_pb[i]);
      c_sgn[i] = cd[i] < 0;
      c_mag[i] = (cd[i] < 0) ? PW'(-cd[i]) : PW'(cd[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
    end else if (adv) begin
      c1_v <= n1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_pa[0] <= fv[1] * upv[2];
      c1_pb[0] <= fv[2] * upv[1];
      c1_pa[1] <= fv[2] * upv[0];
      c1_pb[1] <= fv[0] * upv[2];
      c1_pa[2] <= fv[0] * upv[1];
      c1_pb[2] <= fv[1] * upv[0];
      c1_side.eye <= n1_side.eye;
      c1_side.f   <= n1_vec;
      c1_side.fok <= n1_ok;
    end
  end

  // side vector
  logic               n2_v, n2_ok;
  logic [2:0][FS-1:0] n2_vec;
  n2_side_t           n2_side;

  lav_norm #(
    .MW        (PW),
    .FRAC_BITS (FRAC_BITS),
    .SIDE_BITS ($bits(n2_side_t))
  ) u_norm_side (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (c1_v),
    .in_sgn    (c_sgn),
    .in_mag    (c_mag),
    .in_side   (c1_side),
    .out_valid (n2_v),
    .out_ok    (n2_ok),
    .out_vec   (n2_vec),
    .out_side  (n2_side)
  );

  // true up, dot products
  logic                    u1_v, u2_v, u3_v, u4_v;
  logic signed [FS-1:0]    sv [3];
  logic signed [FS-1:0]    fw [3];
  logic signed [W-1:0]     ew [3];
  logic signed [2*FS-1:0]  u1_ua [3];
  logic signed [2*FS-1:0]  u1_ub [3];
  logic signed [FS+W-1:0]  u1_se [3];
  logic signed [FS+W-1:0]  u1_fe [3];
  logic signed [FS-1:0]    u1_s [3];
  logic signed [FS-1:0]    u1_f [3];
  logic signed [W-1:0]     u1_e [3];
  logic                    u1_deg;
  logic signed [W-1:0]     u2_u [3];
  logic signed [FS-1:0]    u2_s [3];
  logic signed [FS-1:0]    u2_f [3];
  logic signed [W-1:0]     u2_e [3];
  logic signed [W-1:0]     u2_c0, u2_c2;
  logic                    u2_deg;
  logic signed [2*W-1:0]   u3_ue [3];
  logic signed [W-1:0]     u3_u [3];
  logic signed [FS-1:0]    u3_s [3];
  logic signed [FS-1:0]    u3_f [3];
  logic signed [W-1:0]     u3_c0, u3_c2;
  logic                    u3_deg;
  logic signed [W-1:0]     u4_u [3];
  logic signed [FS-1:0]    u4_s [3];
  logic signed [FS-1:0]    u4_f [3];
  logic signed [W-1:0]     u4_c0, u4_c1, u4_c2;
  logic                    u4_deg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sv[i] = $signed(n2_vec[i]);
      fw[i] = $signed(n2_side.f[i]);
      ew[i] = $signed(n2_side.eye[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u1_v <= 1'b0;
      u2_v <= 1'b0;
      u3_v <= 1'b0;
      u4_v <= 1'b0;
    end else if (adv) begin
      u1_v <= n2_v;
      u2_v <= u1_v;
      u3_v <= u2_v;
      u4_v <= u3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u1_ua[0] <= sv[1] * fw[2];
      u1_ub[0] <= sv[2] * fw[1];
      u1_ua[1] <= sv[2] * fw[0];
      u1_ub[1] <= sv[0] * fw[2];
      u1_ua[2] <= sv[0] * fw[1];
      u1_ub[2] <= sv[1] * fw[0];
      for (int i = 0; i < 3; i++) begin
        u1_se[i] <= sv[i] * ew[i];
        u1_fe[i] <= fw[i] * ew[i];
        u1_s[i]  <= sv[i];
        u1_f[i]  <= fw[i];
        u1_e[i]  <= ew[i];
      end
      u1_deg <= !(n2_side.fok && n2_ok);

      for (int i = 0; i < 3; i++) begin
        u2_u[i] <= rnd(AW'(u1_ua[i]) - AW'(u1_ub[i]));
        u2_s[i] <= u1_s[i];
        u2_f[i] <= u1_f[i];
        u2_e[i] <= u1_e[i];
      end
      u2_c0  <= rnd(AW'(0) - (AW'(u1_se[0]) + AW'(u1_se[1]) + AW'(u1_se[2])));
      u2_c2  <= rnd(AW'(u1_fe[0]) + AW'(u1_fe[1]) + AW'(u1_fe[2]));
      u2_deg <= u1_deg;

      for (int i = 0; i < 3; i++) begin
        u3_ue[i] <= u2_u[i] * u2_e[i];
        u3_u[i]  <= u2_u[i];
        u3_s[i]  <= u2_s[i];
        u3_f[i]  <= u2_f[i];
      end
      u3_c0  <= u2_c0;
      u3_c2  <= u2_c2;
      u3_deg <= u2_deg;

      u4_u   <= u3_u;
      u4_s   <= u3_s;
      u4_f   <= u3_f;
      u4_c0  <= u3_c0;
      u4_c1  <= rnd(AW'(0) - (AW'(u3_ue[0]) + AW'(u3_ue[1]) + AW'(u3_ue[2])));
      u4_c2  <= u3_c2;
      u4_deg <= u3_deg;
    end
  end

  // row serializer
  logic                o_valid;
  logic [1:0]          o_cnt;
  logic signed [W-1:0] o_s [3];
  logic signed [W-1:0] o_u [3];
  logic signed [W-1:0] o_nf [3];
  logic signed [W-1:0] o_c3 [3];
  logic                o_deg;

  assign adv       = !o_valid || (rsp.ready && o_cnt == lav_pkg::ROW_LAST);
  assign req.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      o_cnt   <= lav_pkg::ROW_SIDE;
    end else if (adv) begin
      o_valid <= u4_v;
      o_cnt   <= lav_pkg::ROW_SIDE;
    end else if (rsp.ready) begin
      o_cnt <= o_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        o_s[i]  <= clamp(AW'(u4_s[i]));
        o_u[i]  <= u4_u[i];
        o_nf[i] <= clamp(AW'(0) - AW'(u4_f[i]));
      end
      o_c3[0] <= u4_c0;
      o_c3[1] <= u4_c1;
      o_c3[2] <= u4_c2;
      o_deg   <= u4_deg;
    end
  end

  always_comb begin
    rsp.valid      = o_valid;
    rsp.row_index  = o_cnt;
    rsp.last_row   = (o_cnt == lav_pkg::ROW_LAST);
    rsp.degenerate = o_deg;
    unique case (o_cnt)
      lav_pkg::ROW_SIDE: begin
        rsp.col0 = o_s[0];
        rsp.col1 = o_s[1];
        rsp.col2 = o_s[2];
        rsp.col3 = o_c3[0];
      end
      lav_pkg::ROW_UP: begin
        rsp.col0 = o_u[0];
        rsp.col1 = o_u[1];
        rsp.col2 = o_u[2];
        rsp.col3 = o_c3[1];
      end
      lav_pkg::ROW_FWD: begin
        rsp.col0 = o_nf[0];
        rsp.col1 = o_nf[1];
        rsp.col2 = o_nf[2];
        rsp.col3 = o_c3[2];
      end
      default: begin
        rsp.col0 = '0;
        rsp.col1 = '0;
        rsp.col2 = '0;
        rsp.col3 = ONE_W;
      end
    endcase
  end

  // a taken row that is not the last steps the row counter and keeps the beat
  a_row_step: assert property (@(posedge clk) disable iff (rst)
    o_valid && rsp.ready && o_cnt != lav_pkg::ROW_LAST
    |=> o_valid && o_cnt == 2'($past(o_cnt) + 2'd1))
    else $error("row counter did not advance");

  // pipeline holds while the serializer is busy
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(u4_v) && $stable(u4_c1) && $stable(t0_v))
    else $error("pipeline moved during stall");

  // flag stays fixed across the rows of one matrix
  a_deg: assert property (@(posedge clk) disable iff (rst)
    o_valid && !adv |=> $stable(o_deg))
    else $error("degenerate flag changed inside a matrix");

  // no request is taken while rows other than the last are pending
  a_accept: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_cnt != lav_pkg::ROW_LAST |-> !req.ready)
    else $error("request taken with rows pending");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int WB          = 32;
  localparam int FB          = 16;
  localparam int LATENCY     = 2 * FB + 80;
  localparam int WATCH_LIMIT = 6000;
  localparam int LONG_HOLD   = 400;

  typedef longint vec_t[3];
  typedef logic signed [127:0] acc_t;

  typedef struct {
    bit                   pause;
    logic signed [WB-1:0] fld[9];
  } view_req_t;

  typedef struct {
    logic [1:0]           idx;
    logic signed [WB-1:0] col[4];
    logic                 last;
    logic                 degen;
  } row_t;

  logic clk;
  logic rst;

  lav_req_if #(.WORD_BITS(WB)) req_ch ();
  lav_rsp_if #(.WORD_BITS(WB)) rsp_ch ();

  look_at_view_matrix_top #(.WORD_BITS(WB), .FRAC_BITS(FB)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  view_req_t pending_reqs[$];
  row_t      expected_rows[$];
  int        mismatches = 0;
  int        reqs_taken = 0;
  int        rows_seen  = 0;
  int        idle_cycles = 0;
  bit        req_fire;
  bit        long_hold_done = 0;
  int        hold_left = 0;

  // ---------------- predictor ----------------
  function automatic longint unsigned abs64(longint a);
    return a < 0 ? longint'(-a) : a;
  endfunction

  function automatic longint rnd_sat(acc_t a);
    acc_t t;
    t = a + ((a < 0) ? acc_t'(32767) : acc_t'(32768));
    t = t >>> FB;
    if (t > acc_t'(64'sd2147483647)) return 64'sd2147483647;
    if (t < -acc_t'(64'sd2147483648)) return -64'sd2147483648;
    return longint'(t);
  endfunction

  function automatic acc_t mul_w(longint a, longint b);
    return acc_t'(a) * acc_t'(b);
  endfunction

  function automatic longint sat_w(longint x);
    return rnd_sat(mul_w(x, 64'sd65536));
  endfunction

  function automatic bit scale_to_window(ref vec_t v);
    longint unsigned m;
    m = 0;
    for (int i = 0; i < 3; i++) if (abs64(v[i]) > m) m = abs64(v[i]);
    if (m == 0) return 0;
    while (m >= (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) v[i] = v[i] / 2;
      m = m >> 1;
    end
    while (m < (64'd1 << 28)) begin
      for (int i = 0; i < 3; i++) v[i] = v[i] * 2;
      m = m << 1;
    end
    return 1;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit unit_vec(vec_t v_in, ref vec_t o);
    vec_t v;
    longint unsigned sum, len, q;
    v = v_in;
    for (int i = 0; i < 3; i++) o[i] = 0;
    if (!scale_to_window(v)) return 0;
    sum = 0;
    for (int i = 0; i < 3; i++) sum += abs64(v[i]) * abs64(v[i]);
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((abs64(v[i]) << FB) + len / 2) / len;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic acc_t dot_w(vec_t a, vec_t b);
    return mul_w(a[0], b[0]) + mul_w(a[1], b[1]) + mul_w(a[2], b[2]);
  endfunction

  function automatic void predict_view_rows(view_req_t r);
    vec_t eye, dir, up, fwd, crs, side, tup;
    bit fok, sok;
    longint m[4][4];
    row_t row;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'(r.fld[i]);
      dir[i] = longint'(r.fld[3+i]) - eye[i];
      up[i]  = longint'(r.fld[6+i]);
    end
    fok = unit_vec(dir, fwd);
    if (!scale_to_window(up)) for (int i = 0; i < 3; i++) up[i] = 0;
    crs[0] = fwd[1] * up[2] - fwd[2] * up[1];
    crs[1] = fwd[2] * up[0] - fwd[0] * up[2];
    crs[2] = fwd[0] * up[1] - fwd[1] * up[0];
    sok = unit_vec(crs, side);
    tup[0] = rnd_sat(mul_w(side[1], fwd[2]) - mul_w(side[2], fwd[1]));
    tup[1] = rnd_sat(mul_w(side[2], fwd[0]) - mul_w(side[0], fwd[2]));
    tup[2] = rnd_sat(mul_w(side[0], fwd[1]) - mul_w(side[1], fwd[0]));
    for (int i = 0; i < 3; i++) begin
      m[0][i] = sat_w(side[i]);
      m[1][i] = tup[i];
      m[2][i] = sat_w(-fwd[i]);
      m[3][i] = 0;
    end
    m[0][3] = rnd_sat(-dot_w(side, eye));
    m[1][3] = rnd_sat(-dot_w(tup, eye));
    m[2][3] = rnd_sat(dot_w(fwd, eye));
    m[3][3] = sat_w(64'sd1 << FB);
    for (int k = 0; k < 4; k++) begin
      row.idx = 2'(k);
      for (int i = 0; i < 4; i++) row.col[i] = m[k][i][WB-1:0];
      row.last  = (k == 3);
      row.degen = !(fok && sok);
      expected_rows.push_back(row);
    end
  endfunction

  // ---------------- clock, reset ----------------
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;
  end

  initial begin
    req_ch.valid    = 0;
    req_ch.eye_x    = '0;
    req_ch.eye_y    = '0;
    req_ch.eye_z    = '0;
    req_ch.target_x = '0;
    req_ch.target_y = '0;
    req_ch.target_z = '0;
    req_ch.upward_x = '0;
    req_ch.upward_y = '0;
    req_ch.upward_z = '0;
    rsp_ch.ready    = 0;
  end

  function automatic int send_idle_pct();
    if (reqs_taken < 75) return 25;
    if (reqs_taken < 150) return 61;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (reqs_taken < 75) return 61;
    if (reqs_taken < 150) return 25;
    return 0;
  endfunction

  // ---------------- driver ----------------
  always @(negedge clk) begin
    if (!rst && !(req_ch.valid && !req_fire)) begin
      if (pending_reqs.size() > 0 && pending_reqs[0].pause) begin
        req_ch.valid <= 0;
        // sender stands still until the block has drained
        if (expected_rows.size() == 0) void'(pending_reqs.pop_front());
      end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
        view_req_t r;
        r = pending_reqs.pop_front();
        req_ch.valid    <= 1;
        req_ch.eye_x    <= r.fld[0];
        req_ch.eye_y    <= r.fld[1];
        req_ch.eye_z    <= r.fld[2];
        req_ch.target_x <= r.fld[3];
        req_ch.target_y <= r.fld[4];
        req_ch.target_z <= r.fld[5];
        req_ch.upward_x <= r.fld[6];
        req_ch.upward_y <= r.fld[7];
        req_ch.upward_z <= r.fld[8];
      end else begin
        req_ch.valid <= 0;
      end
    end
  end

  // ---------------- receiver ready ----------------
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 0;
    end else if (!long_hold_done && reqs_taken >= 40) begin
      long_hold_done <= 1;
      hold_left <= LONG_HOLD;
      rsp_ch.ready <= 0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    bit took;
    took = 0;
    req_fire = 0;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        view_req_t r;
        r.pause = 0;
        r.fld = '{req_ch.eye_x, req_ch.eye_y, req_ch.eye_z,
                  req_ch.target_x, req_ch.target_y, req_ch.target_z,
                  req_ch.upward_x, req_ch.upward_y, req_ch.upward_z};
        predict_view_rows(r);
        req_fire = 1;
        reqs_taken <= reqs_taken + 1;
        took = 1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        row_t want;
        took = 1;
        rows_seen <= rows_seen + 1;
        if (expected_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected row beat: row %0d", rsp_ch.row_index);
        end else begin
          want = expected_rows.pop_front();
          if (rsp_ch.row_index !== want.idx || rsp_ch.col0 !== want.col[0] ||
              rsp_ch.col1 !== want.col[1] || rsp_ch.col2 !== want.col[2] ||
              rsp_ch.col3 !== want.col[3] || rsp_ch.last_row !== want.last ||
              rsp_ch.degenerate !== want.degen) begin
            mismatches++;
            if (mismatches <= 10)
              $display("row mismatch: exp row %0d %h %h %h %h last %b degen %b",
                       want.idx, want.col[0], want.col[1], want.col[2], want.col[3],
                       want.last, want.degen,
                       " / got row %0d %h %h %h %h last %b degen %b",
                       rsp_ch.row_index, rsp_ch.col0, rsp_ch.col1, rsp_ch.col2,
                       rsp_ch.col3, rsp_ch.last_row, rsp_ch.degenerate);
          end
        end
      end
      idle_cycles <= took ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic void add_req(logic signed [WB-1:0] ex, ey, ez, tx, ty, tz,
                                  ux, uy, uz);
    view_req_t r;
    r.pause = 0;
    r.fld = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
    pending_reqs.push_back(r);
  endfunction

  function automatic logic signed [WB-1:0] near_val();
    int sel;
    sel = $urandom_range(3);
    if (sel == 0) return $signed(32'($urandom_range(200))) - 100;
    if (sel == 1) return $signed(32'($urandom_range(32'h0020_0000))) - 32'sh0010_0000;
    if (sel == 2) return $signed(32'($urandom_range(32'h2000_0000))) - 32'sh1000_0000;
    return $urandom;
  endfunction

  localparam logic signed [WB-1:0] MAXW = 32'sh7fff_ffff;
  localparam logic signed [WB-1:0] MINW = 32'sh8000_0000;
  localparam logic signed [WB-1:0] ONE  = 32'sh0001_0000;

  initial begin
    view_req_t gap;
    gap.pause = 1;
    // plain views
    add_req(0, 0, ONE * 5, 0, 0, 0, 0, ONE, 0);
    add_req(ONE, ONE * 2, ONE * 3, -ONE, ONE, 0, 0, 0, ONE);
    // eye on target
    add_req(ONE * 7, -ONE, 3, ONE * 7, -ONE, 3, 0, ONE, 0);
    add_req(MINW, MAXW, 0, MINW, MAXW, 0, ONE, 0, 0);
    // up vector zero, and up along the view direction
    add_req(0, 0, 0, ONE, 0, 0, 0, 0, 0);
    add_req(0, 0, 0, 0, 0, ONE * 4, 0, 0, -ONE);
    add_req(ONE, ONE, ONE, ONE * 3, ONE * 3, ONE * 3, 5, 5, 5);
    // field extremes, saturating translation
    add_req(MAXW, MAXW, MAXW, MINW, MINW, MINW, MAXW, MINW, MAXW);
    add_req(MINW, MINW, MINW, MAXW, MAXW, MAXW, MINW, MAXW, MINW);
    add_req(MAXW, MINW, MAXW, 0, 0, 0, 0, MAXW, 0);
    add_req(MINW, 0, MAXW, MAXW, -1, MINW, -1, 1, -1);
    add_req(-1, -1, -1, 0, 0, 0, 1, 0, 0);
    add_req(1, 0, 0, 0, 1, 0, 0, 0, MINW);
    add_req(MAXW, MAXW, MAXW, MAXW, MAXW, MAXW - 1, MAXW, MAXW, MAXW);
    add_req(32'sh1234_5678, -32'sh0abc_def0, 32'sh7654_3210,
            -32'sh1111_1111, 32'sh2222_2222, -32'sh3333_3333, 1, 2, 3);
    pending_reqs.push_back(gap);
    for (int n = 0; n < 200; n++) begin
      logic signed [WB-1:0] e[3], t[3], u[3];
      int kind;
      kind = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
        e[i] = near_val();
        t[i] = e[i] + near_val();
        u[i] = near_val();
      end
      if (kind == 0) begin
        t = e;
      end else if (kind == 1) begin
        for (int i = 0; i < 3; i++) u[i] = (t[i] - e[i]) * $signed(32'($urandom_range(3)));
      end else if (kind >= 7) begin
        for (int i = 0; i < 3; i++) begin
          e[i] = $urandom;
          t[i] = $urandom;
          u[i] = $urandom;
        end
      end
      add_req(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]);
      if (n == 100) pending_reqs.push_back(gap);
    end

    wait (!rst);
    while (pending_reqs.size() > 0 || req_ch.valid || expected_rows.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
